FILE: hw/rtl/vbgo_pkg.sv
// Shared types and constants for the vertical band gain/offset block.
// No dependencies; every other file imports this package.
package vbgo_pkg;

   // Field widths of the pixel transaction and the configuration registers
   localparam int PixelW      = 8;
   localparam int LineWidthW  = 14;
   localparam int BandW       = 13;
   localparam int GainW       = 12;
   localparam int BiasW       = 9;
   localparam int CsrDataW    = 14;
   localparam int CsrIndexW   = 3;

   // Ramp and fixed-point constants
   localparam int RampSteps    = 4;
   localparam int WeightW      = 3;
   localparam int BandMinStart = 3;
   localparam int UnityGain    = 256;
   localparam int ProductShift = 10;
   localparam int FactorW      = 14;
   localparam int PixelMax     = 255;

   localparam int DefaultMaxLineWidth = 8192;

   // Register reset values
   localparam logic [LineWidthW-1:0] LineWidthReset = LineWidthW'(1024);
   localparam logic [BandW-1:0]      BandStartReset = BandW'(100);
   localparam logic [BandW-1:0]      BandEndReset   = BandW'(200);
   localparam logic [GainW-1:0]      GainReset      = GainW'(256);
   localparam logic [BiasW-1:0]      BiasReset      = '0;

   // Register indexes on the configuration port
   typedef enum logic [CsrIndexW-1:0] {
      CSR_LINE_WIDTH = 3'd0,
      CSR_BAND_START = 3'd1,
      CSR_BAND_END   = 3'd2,
      CSR_GAIN       = 3'd3,
      CSR_BIAS       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [LineWidthW-1:0]   line_width;
      logic [BandW-1:0]        band_start;
      logic [BandW-1:0]        band_end;
      logic [GainW-1:0]        gain;
      logic signed [BiasW-1:0] bias;
   } cfg_type;

   // Contents of the stage register between band decode and arithmetic
   typedef struct packed {
      logic               valid;
      logic [PixelW-1:0]  pixel;
      logic [WeightW-1:0] weight;
   } stage_type;

endpackage

FILE: hw/rtl/vbgo_req_if.sv
// Pixel request channel: valid/ready handshake with pixel and line start.
// Depends on vbgo_pkg for the pixel width.
interface vbgo_req_if import vbgo_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PixelW-1:0] pixel_in;
   logic              line_start;

   modport source (output valid, pixel_in, line_start, input ready);
   modport sink   (input valid, pixel_in, line_start, output ready);
endinterface

FILE: hw/rtl/vbgo_rsp_if.sv
// Pixel response channel: valid/ready handshake with result pixel and band flag.
// Depends on vbgo_pkg for the pixel width.
interface vbgo_rsp_if import vbgo_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PixelW-1:0] pixel_out;
   logic              in_band;

   modport source (output valid, pixel_out, in_band, input ready);
   modport sink   (input valid, pixel_out, in_band, output ready);
endinterface

FILE: hw/rtl/vbgo_csr.sv
// Configuration register file: line width, band limits, gain and bias.
// Depends on vbgo_pkg for widths, reset values and register indexes.
module vbgo_csr import vbgo_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write and update the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_WIDTH: cfg_in.line_width = csr_wdata[LineWidthW-1:0];
            CSR_BAND_START: cfg_in.band_start = csr_wdata[BandW-1:0];
            CSR_BAND_END:   cfg_in.band_end   = csr_wdata[BandW-1:0];
            CSR_GAIN:       cfg_in.gain       = csr_wdata[GainW-1:0];
            CSR_BIAS:       cfg_in.bias       = $signed(csr_wdata[BiasW-1:0]);
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width <= LineWidthReset;
         cfg_ff.band_start <= BandStartReset;
         cfg_ff.band_end   <= BandEndReset;
         cfg_ff.gain       <= GainReset;
         cfg_ff.bias       <= BiasReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/vbgo_band.sv
// Column tracking and band/ramp weight decode, ending in the stage register.
// Depends on vbgo_pkg for the configuration and stage types.
module vbgo_band import vbgo_pkg::*; #(
   parameter int MAX_LINE_WIDTH = DefaultMaxLineWidth
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              accept,
   input  logic              advance,
   input  logic [PixelW-1:0] pixel_in,
   input  logic              line_start,
   output stage_type         stage
);

   localparam int ColW = $clog2(MAX_LINE_WIDTH);
   localparam int CmpW = ((ColW > LineWidthW) ? ColW : LineWidthW) + 2;
   localparam logic [ColW-1:0] ColMax = ColW'(MAX_LINE_WIDTH - 1);

   logic [ColW-1:0]        column_ff;
   logic [ColW-1:0]        column_in;
   logic [ColW-1:0]        col;
   logic [BandW-1:0]       start_raised;
   logic signed [CmpW-1:0] col_s;
   logic signed [CmpW-1:0] start_s;
   logic signed [CmpW-1:0] lim_s;
   logic signed [CmpW-1:0] end_raw_s;
   logic signed [CmpW-1:0] end_s;
   logic signed [CmpW-1:0] dist_lo;
   logic signed [CmpW-1:0] dist_hi;
   logic [WeightW-1:0]     w_core;
   logic [WeightW-1:0]     w_lo;
   logic [WeightW-1:0]     w_hi;
   logic [WeightW-1:0]     w_max;
   logic [WeightW-1:0]     weight;
   logic                   on_line;
   stage_type              stage_ff;

   // Column of this transaction and next count, saturating at the top
   always_comb begin
      col = line_start ? '0 : column_ff;
      column_in = column_ff;
      if (accept) begin
         column_in = (col == ColMax) ? col : col + 1'b1;
      end
   end

   // Band limits: raise start to the minimum, cap end at line width minus ramp
   always_comb begin
      start_raised = (cfg.band_start < BandW'(BandMinStart)) ?
                     BandW'(BandMinStart) : cfg.band_start;
      col_s     = $signed(CmpW'(col));
      start_s   = $signed(CmpW'(start_raised));
      lim_s     = $signed(CmpW'(cfg.line_width)) - $signed(CmpW'(RampSteps));
      end_raw_s = $signed(CmpW'(cfg.band_end));
      end_s     = (end_raw_s > lim_s) ? lim_s : end_raw_s;
      dist_lo   = start_s - col_s;
      dist_hi   = col_s - end_s;
   end

   // Weight: full inside the band, falling ramp on either side; keep the highest
   always_comb begin
      w_core = (col_s >= start_s && col_s <= end_s) ? WeightW'(RampSteps) : '0;
      w_lo = '0;
      if (dist_lo >= $signed(CmpW'(1)) && dist_lo < $signed(CmpW'(RampSteps))) begin
         w_lo = WeightW'(RampSteps) - WeightW'(dist_lo[1:0]);
      end
      w_hi = '0;
      if (dist_hi >= $signed(CmpW'(1)) && dist_hi < $signed(CmpW'(RampSteps))) begin
         w_hi = WeightW'(RampSteps) - WeightW'(dist_hi[1:0]);
      end
      w_max = w_core;
      if (w_lo > w_max) begin
         w_max = w_lo;
      end
      if (w_hi > w_max) begin
         w_max = w_hi;
      end
      on_line = CmpW'(col) < CmpW'(cfg.line_width);
      weight  = on_line ? w_max : '0;
   end

   // Hold control state: column count and stage valid; capture the payload on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff      <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         column_ff <= column_in;
         if (advance) begin
            stage_ff.valid <= accept;
         end
      end
      if (accept) begin
         stage_ff.pixel  <= pixel_in;
         stage_ff.weight <= weight;
      end
   end

   assign stage = stage_ff;

`ifndef SYNTHESIS
   a_column_steps: assert property (@(posedge clock) disable iff (reset)
      (accept && !line_start && column_ff != ColMax) |=> column_ff == $past(column_ff) + 1'b1)
      else $error("column count did not advance on an accepted transaction");

   a_column_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && line_start) |=> column_ff == ColW'(1))
      else $error("column count did not restart at line start");

   a_weight_bound: assert property (@(posedge clock) disable iff (reset)
      stage_ff.valid |-> stage_ff.weight <= WeightW'(RampSteps))
      else $error("stage weight exceeds full strength");
`endif

endmodule

FILE: hw/rtl/vbgo_stretch.sv
// Gain and offset arithmetic with clamp, ending in the result register.
// Depends on vbgo_pkg for the configuration and stage types.
module vbgo_stretch import vbgo_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  stage_type         stage,
   input  logic              advance,
   output logic              rsp_valid,
   output logic [PixelW-1:0] rsp_pixel_out,
   output logic              rsp_in_band
);

   localparam int DW    = GainW + 2;
   localparam int KdW   = DW + 2;
   localparam int ProdW = PixelW + FactorW;
   localparam int ScW   = ProdW - ProductShift;
   localparam int BkW   = BiasW + 3;
   localparam int SumW  = ScW + 2;

   logic signed [DW-1:0]   gain_delta;
   logic signed [KdW-1:0]  gain_k;
   logic signed [KdW-1:0]  factor;
   logic [ProdW-1:0]       product;
   logic [ScW-1:0]         scaled;
   logic signed [BkW-1:0]  bias_k;
   logic signed [BkW-1:0]  bias_adj;
   logic signed [SumW-1:0] sum;
   logic [PixelW-1:0]      clamped;
   logic [PixelW-1:0]      result;
   logic                   valid_ff;
   logic [PixelW-1:0]      pixel_ff;
   logic                   in_band_ff;

   // Scale the gain excess and the bias by the ramp weight (shift and add)
   always_comb begin
      gain_delta = $signed(DW'(cfg.gain)) - $signed(DW'(UnityGain));
      case (stage.weight)
         3'd1:    gain_k = KdW'(gain_delta);
         3'd2:    gain_k = KdW'(gain_delta) <<< 1;
         3'd3:    gain_k = (KdW'(gain_delta) <<< 1) + KdW'(gain_delta);
         3'd4:    gain_k = KdW'(gain_delta) <<< 2;
         default: gain_k = '0;
      endcase
      case (stage.weight)
         3'd1:    bias_k = BkW'(cfg.bias);
         3'd2:    bias_k = BkW'(cfg.bias) <<< 1;
         3'd3:    bias_k = (BkW'(cfg.bias) <<< 1) + BkW'(cfg.bias);
         3'd4:    bias_k = BkW'(cfg.bias) <<< 2;
         default: bias_k = '0;
      endcase
   end

   // Multiply by the weighted factor, add the offset rounded toward zero, clamp
   always_comb begin
      factor   = $signed(KdW'(1 << ProductShift)) + gain_k;
      product  = ProdW'(stage.pixel) * ProdW'(factor[FactorW-1:0]);
      scaled   = product[ProdW-1:ProductShift];
      bias_adj = bias_k + (bias_k[BkW-1] ? $signed(BkW'(RampSteps - 1)) : $signed(BkW'(0)));
      sum      = $signed(SumW'(scaled)) + SumW'(bias_adj >>> 2);
      if (sum < $signed(SumW'(0))) begin
         clamped = '0;
      end else if (sum > $signed(SumW'(PixelMax))) begin
         clamped = PixelW'(PixelMax);
      end else begin
         clamped = sum[PixelW-1:0];
      end
      result = (stage.weight != '0) ? clamped : stage.pixel;
   end

   // Hold result valid until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage.valid) begin
         pixel_ff   <= result;
         in_band_ff <= stage.weight != '0;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_pixel_out = pixel_ff;
   assign rsp_in_band   = in_band_ff;

`ifndef SYNTHESIS
   a_flag_follows_weight: assert property (@(posedge clock) disable iff (reset)
      (advance && stage.valid) |=> valid_ff && in_band_ff == ($past(stage.weight) != '0))
      else $error("band flag does not match stage weight");

   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      (advance && stage.valid && stage.weight == '0) |=> pixel_ff == $past(stage.pixel))
      else $error("pixel outside the band was altered");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pixel_ff) && $stable(in_band_ff) && valid_ff)
      else $error("result register changed while stalled");
`endif

endmodule

FILE: hw/rtl/vertical_band_gain_offset.sv
// Vertical band gain/offset: a request passes the stage register, then the result
// register, to the response. One pixel transaction per cycle while responses are
// taken; both registers let a new transaction in while a finished result waits.
// Synchronous active-high reset clears the column count to 0, empties both
// stages and loads the register defaults (width 1024, band 100..200, unity gain).
module vertical_band_gain_offset import vbgo_pkg::*; #(
   parameter int MAX_LINE_WIDTH = DefaultMaxLineWidth
) (
   input  logic                 clock,
   input  logic                 reset,
   vbgo_req_if.sink             req_chan,
   vbgo_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   cfg_type   cfg;
   stage_type stage;
   logic      out_advance;
   logic      stage_advance;
   logic      accept;

   // Advance each stage when the one after it has room
   assign out_advance   = !rsp_chan.valid || rsp_chan.ready;
   assign stage_advance = !stage.valid || out_advance;
   assign req_chan.ready = stage_advance;
   assign accept         = req_chan.valid && stage_advance;

   vbgo_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vbgo_band #(
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
   ) u_band (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .advance    (stage_advance),
      .pixel_in   (req_chan.pixel_in),
      .line_start (req_chan.line_start),
      .stage      (stage)
   );

   vbgo_stretch u_stretch (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .stage         (stage),
      .advance       (out_advance),
      .rsp_valid     (rsp_chan.valid),
      .rsp_pixel_out (rsp_chan.pixel_out),
      .rsp_in_band   (rsp_chan.in_band)
   );

endmodule

FILE: bench/tb.sv
// Self-checking bench for the vertical band gain/offset block: a directed table,
// then random lines under many register settings, scored against a local predictor.
// Depends on vbgo_pkg, vbgo_req_if, vbgo_rsp_if and vertical_band_gain_offset.
module tb;
   import vbgo_pkg::*;

   localparam int ClockPeriod = 10;
   localparam int ResetCycles = 7;
   localparam int DrainCycles = 6;
   localparam int CycleLimit  = 1000000;
   localparam int PhaseItems  = 75;
   localparam int RandPhases  = 12;
   localparam int MaxReported = 10;

   // One result pixel as the response channel carries it
   typedef struct packed {
      logic [PixelW-1:0] pixel_out;
      logic              in_band;
   } pix_result_type;

   // Row of the directed table; typed rows carry their own expected result
   typedef struct packed {
      logic [1:0]        cfg_id;
      logic [PixelW-1:0] pixel;
      logic              line_start;
      logic              typed;
      logic [PixelW-1:0] exp_pixel;
      logic              exp_band;
   } vector_row_type;

   typedef enum logic [1:0] {
      RX_FREE,
      RX_LIGHT,
      RX_HEAVY,
      RX_PERIODIC
   } rx_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0]  csr_wdata;

   vbgo_req_if req_if ();
   vbgo_rsp_if rsp_if ();

   vertical_band_gain_offset dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: register copy and column of the next pixel
   cfg_type          band_cfg;
   logic [BandW-1:0] col_count;
   pix_result_type   expected_pixels[$];

   // Typed expectation for the transaction being driven
   logic           typed_row;
   pix_result_type typed_want;

   int mismatch_count;
   int pixels_checked;
   int settings_count;
   int cycle_count;
   int burst_left;
   bit idle_on;

   vector_row_type dir_rows [24];
   cfg_type        dir_cfgs [4];

   always #(ClockPeriod / 2) clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("cycle limit of %0d reached with %0d results outstanding",
                  CycleLimit, expected_pixels.size());
         $display("tb: FAIL");
         $finish;
      end
   end

   // Weight of a column: 4 in the band, 3..1 on the ramps, highest one wins
   function automatic int band_weight(int col);
      int s, e, w, offs;
      s = int'(band_cfg.band_start);
      e = int'(band_cfg.band_end);
      if (s < BandMinStart) s = BandMinStart;
      if (e > int'(band_cfg.line_width) - 4) e = int'(band_cfg.line_width) - 4;
      w = 0;
      if (col >= s && col <= e) w = RampSteps;
      offs = s - col;
      if (offs >= 1 && offs < RampSteps && RampSteps - offs > w) w = RampSteps - offs;
      offs = col - e;
      if (offs >= 1 && offs < RampSteps && RampSteps - offs > w) w = RampSteps - offs;
      return w;
   endfunction

   // Gain and offset scaled by weight k, clamped to the pixel range
   function automatic logic [PixelW-1:0] stretch_pixel(logic [PixelW-1:0] pix, int k);
      int d, num, v;
      d   = int'(band_cfg.gain) - UnityGain;
      num = (int'(pix) << ProductShift) + k * int'(pix) * d;
      v   = (num >>> ProductShift) + (k * int'($signed(band_cfg.bias))) / RampSteps;
      if (v > PixelMax) v = PixelMax;
      if (v < 0) v = 0;
      return PixelW'(v);
   endfunction

   task automatic report_mismatch(string what, int want_v, int got_v);
      mismatch_count++;
      if (mismatch_count <= MaxReported)
         $display("mismatch at result %0d: %s expected %0d, got %0d",
                  pixels_checked, what, want_v, got_v);
   endtask

   // Predict on each accepted request, score each accepted response
   always @(posedge clock) begin : score
      pix_result_type want, got;
      int             col, w;
      if (reset) begin
         col_count = '0;
         band_cfg  = '{LineWidthReset, BandStartReset, BandEndReset, GainReset, BiasReset};
      end else begin
         if (req_if.valid && req_if.ready) begin
            col = req_if.line_start ? 0 : int'(col_count);
            want.pixel_out = req_if.pixel_in;
            want.in_band   = 1'b0;
            if (col < int'(band_cfg.line_width)) begin
               w = band_weight(col);
               if (w > 0) begin
                  want.pixel_out = stretch_pixel(req_if.pixel_in, w);
                  want.in_band   = 1'b1;
               end
            end
            // hold the column at the top of the counter
            col_count = (col + 1 < DefaultMaxLineWidth) ? BandW'(col + 1)
                                                        : BandW'(DefaultMaxLineWidth - 1);
            if (typed_row) want = typed_want;
            expected_pixels.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.pixel_out = rsp_if.pixel_out;
            got.in_band   = rsp_if.in_band;
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected response, pixel_out", -1, int'(got.pixel_out));
            end else begin
               want = expected_pixels.pop_front();
               pixels_checked++;
               if (got.pixel_out !== want.pixel_out)
                  report_mismatch("pixel_out", int'(want.pixel_out), int'(got.pixel_out));
               if (got.in_band !== want.in_band)
                  report_mismatch("in_band", int'(want.in_band), int'(got.in_band));
            end
         end
      end
   end

   // Stall the response side on a pattern of its own, changing every so often
   always @(negedge clock) begin : rx_stall
      rx_mode_type rx_mode;
      int          rx_left;
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 200);
      end
      rx_left--;
      case (rx_mode)
         RX_FREE:     rsp_if.ready <= 1'b1;
         RX_LIGHT:    rsp_if.ready <= ($urandom_range(0, 3) != 0);
         RX_HEAVY:    rsp_if.ready <= ($urandom_range(0, 3) == 0);
         RX_PERIODIC: rsp_if.ready <= ((cycle_count % 7) < 4);
         default:     rsp_if.ready <= 1'b1;
      endcase
   end

   // Drive one pixel transaction in bursts with random gaps between them
   task automatic send_pixel(logic [PixelW-1:0] pix, logic ls, logic typed,
                             logic [PixelW-1:0] exp_pix, logic exp_band);
      int gap;
      if (burst_left == 0) begin
         gap        = idle_on ? $urandom_range(1, 8) : 0;
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.pixel_in   <= pix;
      req_if.line_start <= ls;
      typed_row  = typed;
      typed_want = '{exp_pix, exp_band};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic idle_req();
      @(negedge clock);
      req_if.valid <= 1'b0;
      typed_row = 1'b0;
   endtask

   // Hold off until every expected result has come, then let the pipe settle
   task automatic wait_drain();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_LINE_WIDTH: band_cfg.line_width = data[LineWidthW-1:0];
         CSR_BAND_START: band_cfg.band_start = data[BandW-1:0];
         CSR_BAND_END:   band_cfg.band_end   = data[BandW-1:0];
         CSR_GAIN:       band_cfg.gain       = data[GainW-1:0];
         CSR_BIAS:       band_cfg.bias       = data[BiasW-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_cfg(cfg_type c);
      write_reg(CSR_LINE_WIDTH, CsrDataW'(c.line_width));
      write_reg(CSR_BAND_START, CsrDataW'(c.band_start));
      write_reg(CSR_BAND_END,   CsrDataW'(c.band_end));
      write_reg(CSR_GAIN,       CsrDataW'(c.gain));
      write_reg(CSR_BIAS,       CsrDataW'({c.bias}));
      @(negedge clock);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // Mostly short lines so the band and both ramps are reached often
   function automatic cfg_type random_cfg();
      cfg_type c;
      int      lw, span;
      case ($urandom_range(0, 9))
         7, 8:    lw = $urandom_range(49, 8192);
         9:       lw = 8192;
         default: lw = $urandom_range(8, 48);
      endcase
      span = (lw < 60) ? lw : 60;
      c.line_width = LineWidthW'(lw);
      c.band_start = ($urandom_range(0, 4) == 0) ? BandW'($urandom_range(0, 8191))
                                                 : BandW'($urandom_range(0, span + 2));
      c.band_end   = ($urandom_range(0, 4) == 0) ? BandW'($urandom_range(0, 8191))
                                                 : BandW'($urandom_range(0, span + 4));
      case ($urandom_range(0, 5))
         0:       c.gain = '0;
         1:       c.gain = GainW'(4095);
         2:       c.gain = GainW'(UnityGain);
         default: c.gain = GainW'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 4))
         0:       c.bias = -9'sd255;
         1:       c.bias = 9'sd255;
         default: c.bias = BiasW'(int'($urandom_range(0, 510)) - 255);
      endcase
      return c;
   endfunction

   // Well-formed lines with random pixels, plus stray and missing line starts
   task automatic run_phase(cfg_type c, int n_items);
      int line_len, line_pos, lw;
      logic ls;
      idle_req();
      wait_drain();
      apply_cfg(c);
      idle_on  = ($urandom_range(0, 2) != 0);
      lw       = int'(c.line_width);
      line_pos = 0;
      line_len = 0;
      for (int i = 0; i < n_items; i++) begin
         if (line_pos >= line_len) begin
            line_len = ((lw < 64) ? lw : 64) + $urandom_range(0, 4);
            line_pos = 0;
            ls       = ($urandom_range(0, 19) != 0);
         end else begin
            ls = ($urandom_range(0, 49) == 0);
         end
         send_pixel(PixelW'($urandom_range(0, 255)), ls, 1'b0, '0, 1'b0);
         line_pos++;
      end
   endtask

   initial begin : stimulus
      int cur_cfg;
      clock             = 1'b0;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_LINE_WIDTH;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.pixel_in   = '0;
      req_if.line_start = 1'b0;
      rsp_if.ready      = 1'b0;
      typed_row         = 1'b0;
      typed_want        = '0;
      mismatch_count    = 0;
      pixels_checked    = 0;
      settings_count    = 0;
      cycle_count       = 0;
      burst_left        = 0;
      idle_on           = 1'b1;

      // tiny line; empty band with crossing ramps at zero gain; full gain and bias
      dir_cfgs[0] = '{LineWidthReset, BandStartReset, BandEndReset, GainReset, BiasReset};
      dir_cfgs[1] = '{line_width: 14'd8, band_start: 13'd0, band_end: 13'd8191,
                      gain: 12'd512, bias: 9'sd10};
      dir_cfgs[2] = '{line_width: 14'd64, band_start: 13'd5, band_end: 13'd3,
                      gain: 12'd0, bias: -9'sd255};
      dir_cfgs[3] = '{line_width: 14'd16, band_start: 13'd0, band_end: 13'd15,
                      gain: 12'd4095, bias: 9'sd255};

      dir_rows = '{
         // register defaults, no line start: columns 0..2 lie far from the band
         '{2'd0, 8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
         '{2'd0, 8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
         '{2'd0, 8'hA5,  1'b0, 1'b1, 8'hA5,  1'b0},
         // width 8: ramp, band at columns 3..4, ramp, then past the line
         '{2'd1, 8'd200, 1'b1, 1'b0, 8'd0,   1'b0},
         '{2'd1, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
         '{2'd1, 8'd128, 1'b0, 1'b0, 8'd0,   1'b0},
         '{2'd1, 8'd255, 1'b0, 1'b1, 8'd255, 1'b1},
         '{2'd1, 8'd0,   1'b0, 1'b1, 8'd10,  1'b1},
         '{2'd1, 8'd50,  1'b0, 1'b0, 8'd0,   1'b0},
         '{2'd1, 8'd1,   1'b0, 1'b0, 8'd0,   1'b0},
         '{2'd1, 8'd255, 1'b0, 1'b1, 8'd255, 1'b1},
         '{2'd1, 8'd99,  1'b0, 1'b1, 8'd99,  1'b0},
         // empty band: ramps around start and end overlap
         '{2'd2, 8'd77,  1'b1, 1'b1, 8'd77,  1'b0},
         '{2'd2, 8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
         '{2'd2, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
         '{2'd2, 8'd128, 1'b0, 1'b0, 8'd0,   1'b0},
         '{2'd2, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
         '{2'd2, 8'd200, 1'b0, 1'b0, 8'd0,   1'b0},
         '{2'd2, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
         '{2'd2, 8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
         // largest gain and bias
         '{2'd3, 8'd0,   1'b1, 1'b0, 8'd0,   1'b0},
         '{2'd3, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
         '{2'd3, 8'd1,   1'b0, 1'b0, 8'd0,   1'b0},
         '{2'd3, 8'd0,   1'b0, 1'b1, 8'd255, 1'b1}
      };

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table, reprogramming whenever the setting changes
      cur_cfg = 0;
      foreach (dir_rows[i]) begin
         if (int'(dir_rows[i].cfg_id) != cur_cfg) begin
            idle_req();
            wait_drain();
            cur_cfg = int'(dir_rows[i].cfg_id);
            apply_cfg(dir_cfgs[cur_cfg]);
         end
         send_pixel(dir_rows[i].pixel, dir_rows[i].line_start, dir_rows[i].typed,
                    dir_rows[i].exp_pixel, dir_rows[i].exp_band);
      end

      // extremes first, then random settings
      run_phase('{line_width: 14'd8, band_start: 13'd0, band_end: 13'd8191,
                  gain: 12'd0, bias: -9'sd255}, PhaseItems);
      run_phase('{line_width: 14'd8192, band_start: 13'd2, band_end: 13'd40,
                  gain: 12'd4095, bias: 9'sd255}, PhaseItems);
      for (int ph = 2; ph < RandPhases; ph++)
         run_phase(random_cfg(), PhaseItems);

      idle_req();
      wait_drain();

      $display("summary: %0d pixel results checked under %0d register settings",
               pixels_checked, settings_count);
      $display("summary: directed table, then random lines with stray line starts; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/vbgo_pkg.sv
hw/rtl/vbgo_req_if.sv
hw/rtl/vbgo_rsp_if.sv
hw/rtl/vbgo_csr.sv
hw/rtl/vbgo_band.sv
hw/rtl/vbgo_stretch.sv
hw/rtl/vertical_band_gain_offset.sv
bench/tb.sv
